### rtl/i2c_sensor_xy_read_sequencer_core_macros.svh
// Assertion macros for the sensor read sequencer.
`ifndef I2C_SENSOR_XY_READ_SEQUENCER_CORE_MACROS_SVH
`define I2C_SENSOR_XY_READ_SEQUENCER_CORE_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define ISXRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check, held across reset as well.
`define ISXRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/isxrs_pkg.sv
// Types, codes and constants shared by the sensor read sequencer.
`default_nettype none
package isxrs_pkg;

  // Number of data bytes fetched per read (legal range 2 to 8).
  localparam int ReadBytes  = 4;
  localparam int StoreDepth = (ReadBytes > 4) ? ReadBytes : 4;
  localparam int RxCntW     = $clog2(ReadBytes + 1);
  localparam int RxIdxW     = $clog2(StoreDepth);

  localparam logic [7:0] RegAddrByte = 8'h12;

  // Actions
  localparam logic [1:0] ActStart  = 2'd0;
  localparam logic [1:0] ActEvent  = 2'd1;
  localparam logic [1:0] ActTake   = 2'd2;
  localparam logic [1:0] ActCancel = 2'd3;

  // Sequencer modes
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  // Bus commands
  localparam logic [2:0] CmdNone    = 3'd0;
  localparam logic [2:0] CmdWrite1  = 3'd1;
  localparam logic [2:0] CmdSendReg = 3'd2;
  localparam logic [2:0] CmdRead    = 3'd3;
  localparam logic [2:0] CmdRecover = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] start_phase;
    logic        bus_busy;
    logic        flag_nack;
    logic        flag_bus_error;
    logic        flag_tx_ready;
    logic        flag_transfer_done;
    logic        flag_rx_ready;
    logic        flag_stop;
    logic [7:0]  rx_byte;
    logic [15:0] timer_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         bus_command;
    logic               accepted;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic [15:0]        sample_start;
    logic [15:0]        sample_end;
    logic [31:0]        sample_seq;
    logic [31:0]        nack_total;
    logic [31:0]        error_total;
    logic [31:0]        recover_total;
    logic [1:0]         phase_now;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/i2c_sensor_xy_read_sequencer_core.sv
// Sensor X/Y read sequencer: drives I2C master commands and hands out samples.
// Result valid on out_valid_o once its input transfer has passed the input
// register, then the result register; a stall on the result side can hold it.
// Throughput: one item per cycle while the result side does not stall; the state
// update sits between the input register and the result register; nothing iterates.
// Reset: asynchronous, active low; mode idle, counters, held sample and flags cleared,
// receive byte store is not cleared (only read after being written).
`default_nettype none
module i2c_sensor_xy_read_sequencer_core
  import isxrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_item_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_item_o
);

`include "i2c_sensor_xy_read_sequencer_core_macros.svh"

  // ---------------------------------------------------------------------------
  // Handshake: input register -> state update -> result register.
  // The input register can fill while a finished result still sits stalled.
  // ---------------------------------------------------------------------------
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      in_xfer;
  logic      adv;

  assign adv        = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [1:0]        mode_q, mode_d;
  logic [RxCntW-1:0] cnt_q, cnt_d;
  logic [15:0]       pend_start_q, pend_start_d;
  logic [15:0]       held_x_q, held_x_d;
  logic [15:0]       held_y_q, held_y_d;
  logic [15:0]       held_start_q, held_start_d;
  logic [15:0]       held_end_q, held_end_d;
  logic [31:0]       seq_q, seq_d;
  logic              ready_q, ready_d;
  logic [31:0]       nack_q, nack_d;
  logic [31:0]       err_q, err_d;
  logic [31:0]       recov_q, recov_d;

  // Receive byte store; entries past ReadBytes are never written.
  logic [7:0]        rx_store_q [StoreDepth];
  logic              store_we;
  logic [RxIdxW-1:0] wr_idx;
  logic [7:0]        rd_byte [4];
  out_item_t         res;

  assign wr_idx = cnt_q[RxIdxW-1:0];

  // Bytes as seen after this event's write, so a last byte and a stop
  // arriving together still form the sample. Slots past the read length read 0.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k >= ReadBytes) begin
        rd_byte[k] = '0;
      end else if (store_we && (wr_idx == RxIdxW'(k))) begin
        rd_byte[k] = s1_item_q.rx_byte;
      end else begin
        rd_byte[k] = rx_store_q[k];
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    pend_start_d = pend_start_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    seq_d        = seq_q;
    ready_d      = ready_q;
    nack_d       = nack_q;
    err_d        = err_q;
    recov_d      = recov_q;
    store_we     = 1'b0;
    res          = '0;

    unique case (s1_item_q.action)
      ActStart: begin
        if (mode_q == ModeIdle && !s1_item_q.bus_busy) begin
          pend_start_d    = s1_item_q.start_phase;
          cnt_d           = '0;
          mode_d          = ModeWrite;
          res.bus_command = CmdWrite1;
          res.accepted    = 1'b1;
        end
      end
      ActEvent: begin
        if (s1_item_q.flag_nack || s1_item_q.flag_bus_error) begin
          // failure wins over every other flag, in every mode
          if (s1_item_q.flag_nack)      nack_d = nack_q + 32'd1;
          if (s1_item_q.flag_bus_error) err_d  = err_q + 32'd1;
          recov_d         = recov_q + 32'd1;
          mode_d          = ModeIdle;
          res.bus_command = CmdRecover;
        end else if (mode_q == ModeWrite && s1_item_q.flag_tx_ready) begin
          res.bus_command = CmdSendReg;
        end else if (mode_q == ModeWrite && s1_item_q.flag_transfer_done) begin
          mode_d          = ModeRead;
          cnt_d           = '0;
          res.bus_command = CmdRead;
        end else begin
          if (mode_q == ModeRead && s1_item_q.flag_rx_ready &&
              cnt_q < RxCntW'(ReadBytes)) begin
            store_we = 1'b1;
            cnt_d    = cnt_q + RxCntW'(1);
          end
          if (s1_item_q.flag_stop) begin
            if (mode_q == ModeRead && cnt_d == RxCntW'(ReadBytes)) begin
              held_x_d     = {rd_byte[0], rd_byte[1]};
              held_y_d     = {rd_byte[2], rd_byte[3]};
              held_start_d = pend_start_q;
              held_end_d   = s1_item_q.timer_now;
              seq_d        = seq_q + 32'd1;
              ready_d      = 1'b1;
            end
            mode_d = ModeIdle;
          end
        end
      end
      ActTake: begin
        if (ready_q) begin
          res.accepted     = 1'b1;
          res.sample_x     = held_x_q;
          res.sample_y     = held_y_q;
          res.sample_start = held_start_q;
          res.sample_end   = held_end_q;
          res.sample_seq   = seq_q;
          ready_d          = 1'b0;
        end
      end
      ActCancel: begin
        // held sample stays ready
        mode_d = ModeIdle;
        cnt_d  = '0;
      end
      default: ;
    endcase

    res.nack_total    = nack_d;
    res.error_total   = err_d;
    res.recover_total = recov_d;
    res.phase_now     = mode_d;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      mode_q       <= ModeIdle;
      cnt_q        <= '0;
      pend_start_q <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_start_q <= '0;
      held_end_q   <= '0;
      seq_q        <= '0;
      ready_q      <= 1'b0;
      nack_q       <= '0;
      err_q        <= '0;
      recov_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        mode_q       <= mode_d;
        cnt_q        <= cnt_d;
        pend_start_q <= pend_start_d;
        held_x_q     <= held_x_d;
        held_y_q     <= held_y_d;
        held_start_q <= held_start_d;
        held_end_q   <= held_end_d;
        seq_q        <= seq_d;
        ready_q      <= ready_d;
        nack_q       <= nack_d;
        err_q        <= err_d;
        recov_q      <= recov_d;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
    if (adv) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && store_we) begin
      rx_store_q[wr_idx] <= s1_item_q.rx_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ISXRS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= RxCntW'(ReadBytes), "byte count past read length")
  `ISXRS_ASSERT(a_ready_seq, $rose(ready_q) |-> (seq_q != $past(seq_q)), "sample ready without new sequence number")
  `ISXRS_ASSERT(a_recover_idle, (out_valid_o && (out_item_o.bus_command == CmdRecover)) |-> (out_item_o.phase_now == ModeIdle), "recovery result not idle")

endmodule
`default_nettype wire

### test/i2c_sensor_xy_read_sequencer_core_test.sv
// Self-checking testbench for the sensor X/Y read sequencer core.
module i2c_sensor_xy_read_sequencer_core_test;
  import isxrs_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  i2c_sensor_xy_read_sequencer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bus items waiting to be offered, and sequencer results owed by the block.
  in_item_t  bus_items[$];
  out_item_t seq_results_due[$];

  int  fail_count   = 0;
  int  results_seen = 0;
  logic hold_off    = 1'b0;

  // Sequencer state as the block should hold it.
  logic [1:0]        sq_mode     = ModeIdle;
  logic [7:0]        rx_buf[StoreDepth];
  logic [RxCntW-1:0] rx_cnt      = '0;
  logic [15:0]       open_stamp  = '0;
  logic [15:0]       hold_x      = '0;
  logic [15:0]       hold_y      = '0;
  logic [15:0]       hold_start  = '0;
  logic [15:0]       hold_end    = '0;
  logic [31:0]       sample_no   = '0;
  logic              have_sample = 1'b0;
  logic [31:0]       nack_cnt    = '0;
  logic [31:0]       err_cnt     = '0;
  logic [31:0]       recov_cnt   = '0;

  // Bytes past the read length count as zero when X and Y are built.
  function automatic logic [7:0] xy_byte(int idx);
    return (idx < ReadBytes) ? rx_buf[idx] : 8'h00;
  endfunction

  // Applies one transfer to the sequencer state and returns the result it owes.
  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ActStart: begin
        // only from idle with a free bus
        if (sq_mode == ModeIdle && !it.bus_busy) begin
          open_stamp    = it.start_phase;
          rx_cnt        = '0;
          sq_mode       = ModeWrite;
          r.bus_command = CmdWrite1;
          r.accepted    = 1'b1;
        end
      end
      ActEvent: begin
        if (it.flag_nack || it.flag_bus_error) begin
          // failure wins in every mode; rest of the event is dropped
          if (it.flag_nack) nack_cnt++;
          if (it.flag_bus_error) err_cnt++;
          recov_cnt++;
          sq_mode       = ModeIdle;
          r.bus_command = CmdRecover;
        end else if (sq_mode == ModeWrite && it.flag_tx_ready) begin
          r.bus_command = CmdSendReg;
        end else if (sq_mode == ModeWrite && it.flag_transfer_done) begin
          sq_mode       = ModeRead;
          rx_cnt        = '0;
          r.bus_command = CmdRead;
        end else begin
          // receive first, then a stop in the same event
          if (sq_mode == ModeRead && it.flag_rx_ready && rx_cnt < ReadBytes) begin
            rx_buf[rx_cnt] = it.rx_byte;
            rx_cnt++;
          end
          if (it.flag_stop) begin
            if (sq_mode == ModeRead && rx_cnt == ReadBytes) begin
              hold_x      = {xy_byte(0), xy_byte(1)};
              hold_y      = {xy_byte(2), xy_byte(3)};
              hold_start  = open_stamp;
              hold_end    = it.timer_now;
              sample_no++;
              have_sample = 1'b1;
            end
            sq_mode = ModeIdle;
          end
        end
      end
      ActTake: begin
        if (have_sample) begin
          r.accepted     = 1'b1;
          r.sample_x     = hold_x;
          r.sample_y     = hold_y;
          r.sample_start = hold_start;
          r.sample_end   = hold_end;
          r.sample_seq   = sample_no;
          have_sample    = 1'b0;
        end
      end
      ActCancel: begin
        // held sample survives a cancel
        sq_mode = ModeIdle;
        rx_cnt  = '0;
      end
      default: ;
    endcase
    r.nack_total    = nack_cnt;
    r.error_total   = err_cnt;
    r.recover_total = recov_cnt;
    r.phase_now     = sq_mode;
    return r;
  endfunction

  // Bus event with the given flags; the unused fields carry random junk.
  function automatic in_item_t ev(bit nack, bit berr, bit txr, bit tcd, bit rxr, bit stp);
    in_item_t    it;
    logic [31:0] r1;
    logic [31:0] r2;
    r1 = $urandom;
    r2 = $urandom;
    it.action             = ActEvent;
    it.start_phase        = r1[15:0];
    it.bus_busy           = r1[16];
    it.flag_nack          = nack;
    it.flag_bus_error     = berr;
    it.flag_tx_ready      = txr;
    it.flag_transfer_done = tcd;
    it.flag_rx_ready      = rxr;
    it.flag_stop          = stp;
    it.rx_byte            = r1[31:24];
    it.timer_now          = r2[15:0];
    return it;
  endfunction

  // Start, take or cancel; the event flags are random since they must be ignored.
  function automatic in_item_t act(logic [1:0] kind, logic [15:0] stamp, bit busy);
    in_item_t    it;
    logic [31:0] r;
    r = $urandom;
    it = ev(r[0], r[1], r[2], r[3], r[4], r[5]);
    it.action      = kind;
    it.start_phase = stamp;
    it.bus_busy    = busy;
    return it;
  endfunction

  // One full register write plus data read; a broken one gets a fault spliced in.
  task automatic queue_xy_read(bit broken);
    in_item_t    steps[$];
    logic [31:0] r;
    int          n_bytes;
    int          cut;
    bit          merged;
    r       = $urandom;
    n_bytes = ReadBytes;
    if (broken && r[20]) n_bytes = $urandom_range(0, ReadBytes + 2);
    merged = r[21];
    steps.push_back(act(ActStart, r[15:0], broken && r[23:22] == 2'b00));
    // flags that lose to tx_ready / transfer_done ride along at random
    steps.push_back(ev(1'b0, 1'b0, 1'b1, r[24], r[25], r[26]));
    steps.push_back(ev(1'b0, 1'b0, 1'b0, 1'b1, r[27], r[28]));
    for (int i = 0; i < n_bytes; i++) begin
      r = $urandom;
      steps.push_back(ev(1'b0, 1'b0, r[0], r[1], 1'b1, merged && i == n_bytes - 1));
    end
    if (!merged || n_bytes == 0) steps.push_back(ev(1'b0, 1'b0, 1'b0, 1'b0, r[2], 1'b1));
    if (broken) begin
      r   = $urandom;
      cut = $urandom_range(1, steps.size() - 1);
      case (r[1:0])
        2'd0: steps.insert(cut, ev(r[2], !r[2] || r[3], r[4], r[5], r[6], r[7]));
        2'd1: steps.insert(cut, act(ActCancel, r[31:16], r[8]));
        2'd2: steps.delete(cut);
        default: steps.insert(cut, act(ActStart, r[31:16], r[8]));
      endcase
    end
    foreach (steps[i]) bus_items.push_back(steps[i]);
    r = $urandom;
    if (r[1:0] != 2'b00) bus_items.push_back(act(ActTake, r[31:16], r[2]));
    if (r[5:3] == 3'b000) bus_items.push_back(act(ActTake, r[15:0], r[6]));
  endtask

  // Per-transfer wait, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(15, 60);
    return $urandom_range(0, 12);
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) report($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endtask

  // Driver: offers bus_items in order and predicts each one as it is taken.
  int send_wait = 0;
  int send_calm = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
      send_calm = 0;
    end else begin
      if (in_valid && !in_stall) seq_results_due.push_back(step_sequencer(in_item));
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (bus_items.size() > 0) begin
          in_item   <= bus_items.pop_front();
          in_valid  <= 1'b1;
          send_wait = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest owed result.
  int take_wait = 0;
  int take_calm = 0;

  always @(posedge clk or negedge rst_n) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      take_wait = 0;
      take_calm = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (seq_results_due.size() == 0) begin
          report($sformatf("result with nothing owed: bus_command %h, phase_now %h",
                           out_item.bus_command, out_item.phase_now));
        end else begin
          want = seq_results_due.pop_front();
          check_field("bus_command", want.bus_command, out_item.bus_command);
          check_field("accepted", want.accepted, out_item.accepted);
          check_field("sample_x", want.sample_x, out_item.sample_x);
          check_field("sample_y", want.sample_y, out_item.sample_y);
          check_field("sample_start", want.sample_start, out_item.sample_start);
          check_field("sample_end", want.sample_end, out_item.sample_end);
          check_field("sample_seq", want.sample_seq, out_item.sample_seq);
          check_field("nack_total", want.nack_total, out_item.nack_total);
          check_field("error_total", want.error_total, out_item.error_total);
          check_field("recover_total", want.recover_total, out_item.recover_total);
          check_field("phase_now", want.phase_now, out_item.phase_now);
        end
        take_wait = draw_wait(take_calm);
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (take_wait > 0) begin
        take_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Back-pressure: one long hold on the result side while items keep coming,
  // so the pipeline fills and the block stalls its input.
  initial begin
    while (results_seen < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3000000;
    $display("i2c_sensor_xy_read_sequencer_core verification failed");
    $finish;
  end

  initial begin
    in_item_t    it;
    logic [31:0] r;
    int          pick;

    // Directed: empty take, stray stop, busy bus, full-scale stamps and data.
    bus_items.push_back(act(ActTake, 16'h0000, 1'b1));
    bus_items.push_back(ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    bus_items.push_back(act(ActStart, 16'h1234, 1'b1));
    bus_items.push_back(act(ActStart, 16'hFFFF, 1'b0));
    bus_items.push_back(act(ActStart, 16'h0000, 1'b0));
    // tx_ready beats transfer_done; stop in the same event goes unseen
    bus_items.push_back(ev(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
    bus_items.push_back(ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    // X = most negative, Y = most positive, stop merged with the last byte
    it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); it.rx_byte = 8'h80; bus_items.push_back(it);
    it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); it.rx_byte = 8'h00; bus_items.push_back(it);
    it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0); it.rx_byte = 8'h7F; bus_items.push_back(it);
    it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    it.rx_byte   = 8'hFF;
    it.timer_now = 16'hFFFF;
    bus_items.push_back(it);
    bus_items.push_back(ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    bus_items.push_back(act(ActTake, 16'hFFFF, 1'b0));
    bus_items.push_back(act(ActTake, 16'hFFFF, 1'b0));
    // NACK in write, then both failures at once while idle
    bus_items.push_back(act(ActStart, 16'h0000, 1'b0));
    bus_items.push_back(ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    bus_items.push_back(ev(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // one byte too many is dropped, separate stop at timer zero
    bus_items.push_back(act(ActStart, 16'h0001, 1'b0));
    bus_items.push_back(ev(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    for (int i = 0; i <= ReadBytes; i++) begin
      it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      it.rx_byte = (i == ReadBytes) ? 8'hFF : 8'h00;
      bus_items.push_back(it);
    end
    it = ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    it.timer_now = 16'h0000;
    bus_items.push_back(it);
    // cancel mid-write leaves the held sample ready
    bus_items.push_back(act(ActStart, 16'h8000, 1'b0));
    bus_items.push_back(act(ActCancel, 16'hFFFF, 1'b1));
    bus_items.push_back(act(ActTake, 16'h0000, 1'b0));

    // Random: mostly clean reads, some broken ones, noise and loose takes.
    while (bus_items.size() < 1850) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_xy_read(1'b0);
      end else if (pick == 7) begin
        queue_xy_read(1'b1);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) begin
          r  = $urandom;
          it = ev(r[0], r[1], r[2], r[3], r[4], r[5]);
          it.action   = r[7:6];
          it.bus_busy = r[8];
          bus_items.push_back(it);
        end
      end else begin
        r = $urandom;
        bus_items.push_back(act(ActTake, r[15:0], r[16]));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (bus_items.size() != 0 || in_valid || seq_results_due.size() != 0) @(posedge clk);
    // past the input and result registers; anything arriving now is unowed
    repeat (10) @(posedge clk);

    if (fail_count == 0 && seq_results_due.size() == 0) begin
      $display("i2c_sensor_xy_read_sequencer_core verification clean");
    end else begin
      $display("i2c_sensor_xy_read_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
